// ===== sv/lrfs_pkg.sv =====
// Shared types and constants for the LCD rectangle fill sequencer.
// Holds the command and output word structs, configuration view and phase codes.
// Depends on nothing; every other file uses it by scoped names.
`default_nettype none

package lrfs_pkg;

  // Largest panel side used for clipping
  localparam logic [9:0] MAX_SIDE = 10'd512;

  // Panel command bytes
  localparam logic [7:0] CMD_COLUMN_SET = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET    = 8'h2B;
  localparam logic [7:0] CMD_RAM_WRITE  = 8'h2C;

  // Operation codes of a command word
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_PANEL_WIDTH   = 2'd0;
  localparam logic [1:0] REG_PANEL_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_COLUMN_OFFSET = 2'd2;
  localparam logic [1:0] REG_ROW_OFFSET    = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_CASET  = 4'd1,
    PH_CBYTE0 = 4'd2,
    PH_CBYTE1 = 4'd3,
    PH_CBYTE2 = 4'd4,
    PH_CBYTE3 = 4'd5,
    PH_RASET  = 4'd6,
    PH_RBYTE0 = 4'd7,
    PH_RBYTE1 = 4'd8,
    PH_RBYTE2 = 4'd9,
    PH_RBYTE3 = 4'd10,
    PH_RAMWR  = 4'd11,
    PH_PIXEL  = 4'd12
  } phase_t;

  typedef struct packed {
    logic        operation;
    logic [8:0]  rect_x;
    logic [8:0]  rect_y;
    logic [9:0]  rect_w;
    logic [9:0]  rect_h;
    logic [15:0] fill_color;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last_byte;
  } lcd_t;

  // Configuration as seen by the sequencer, panel sides already saturated
  typedef struct packed {
    logic [9:0] panel_w;
    logic [9:0] panel_h;
    logic [7:0] col_off;
    logic [7:0] row_off;
  } cfg_t;

endpackage

`default_nettype wire

// ===== sv/lrfs_cfg_regs.sv =====
// Configuration register file of the LCD rectangle fill sequencer.
// Takes register writes and presents the saturated panel sides and offsets.
// Depends on lrfs_pkg.
`default_nettype none

module lrfs_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire logic [1:0]    wr_index,
  input  wire logic [15:0]   wr_data,
  output lrfs_pkg::cfg_t     cfg
);

  logic [9:0] panel_width;
  logic [9:0] panel_height;
  logic [7:0] column_offset;
  logic [7:0] row_offset;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width   <= 10'd100;
      panel_height  <= 10'd100;
      column_offset <= 8'd0;
      row_offset    <= 8'd0;
    end else if (wr_en) begin
      case (wr_index)
        lrfs_pkg::REG_PANEL_WIDTH:   panel_width   <= wr_data[9:0];
        lrfs_pkg::REG_PANEL_HEIGHT:  panel_height  <= wr_data[9:0];
        lrfs_pkg::REG_COLUMN_OFFSET: column_offset <= wr_data[7:0];
        lrfs_pkg::REG_ROW_OFFSET:    row_offset    <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  // Saturate the panel sides for clipping
  always_comb begin
    cfg.panel_w = (panel_width > lrfs_pkg::MAX_SIDE) ? lrfs_pkg::MAX_SIDE : panel_width;
    cfg.panel_h = (panel_height > lrfs_pkg::MAX_SIDE) ? lrfs_pkg::MAX_SIDE : panel_height;
    cfg.col_off = column_offset;
    cfg.row_off = row_offset;
  end

endmodule

`default_nettype wire

// ===== sv/lrfs_seq_core.sv =====
// Sequencing core of the LCD rectangle fill sequencer.
// Latches clipped rectangles on start words and yields one panel byte per tick while a fill is in progress.
// Depends on lrfs_pkg.
`default_nettype none

module lrfs_seq_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,
  input  wire lrfs_pkg::cmd_t item,
  input  wire lrfs_pkg::cfg_t cfg,
  output logic                has_result,
  output lrfs_pkg::lcd_t      result
);

  lrfs_pkg::phase_t phase, phase_next;
  logic [9:0]  col_start, col_start_next;
  logic [9:0]  col_end, col_end_next;
  logic [9:0]  row_start, row_start_next;
  logic [9:0]  row_end, row_end_next;
  logic [15:0] held_color, held_color_next;
  logic [18:0] pixels_left, pixels_left_next;
  logic        low_half_next, low_half_next_next;

  // Start word arithmetic
  logic [10:0] x_plus_w, y_plus_h;
  logic [9:0]  w_clip, h_clip;
  logic [19:0] area;
  logic        start_ok;
  // Offset addresses
  logic [10:0] col_s_a, col_e_a, row_s_a, row_e_a;
  logic [18:0] pixels_dec;

  // Clip the rectangle to the panel
  always_comb begin
    x_plus_w = {2'b0, item.rect_x} + {1'b0, item.rect_w};
    y_plus_h = {2'b0, item.rect_y} + {1'b0, item.rect_h};
    w_clip   = (x_plus_w > {1'b0, cfg.panel_w}) ? (cfg.panel_w - {1'b0, item.rect_x})
                                                : item.rect_w;
    h_clip   = (y_plus_h > {1'b0, cfg.panel_h}) ? (cfg.panel_h - {1'b0, item.rect_y})
                                                : item.rect_h;
    area     = w_clip * h_clip;
    start_ok = ({1'b0, item.rect_x} < cfg.panel_w) && ({1'b0, item.rect_y} < cfg.panel_h);
    col_s_a  = {1'b0, col_start} + {3'b0, cfg.col_off};
    col_e_a  = {1'b0, col_end} + {3'b0, cfg.col_off};
    row_s_a  = {1'b0, row_start} + {3'b0, cfg.row_off};
    row_e_a  = {1'b0, row_end} + {3'b0, cfg.row_off};
    pixels_dec = (pixels_left != 19'd0) ? (pixels_left - 19'd1) : pixels_left;
  end

  // Next state and output byte
  always_comb begin
    phase_next         = phase;
    col_start_next     = col_start;
    col_end_next       = col_end;
    row_start_next     = row_start;
    row_end_next       = row_end;
    held_color_next    = held_color;
    pixels_left_next   = pixels_left;
    low_half_next_next = low_half_next;
    has_result         = 1'b0;
    result             = '0;

    if (fire && item.operation == lrfs_pkg::OP_START) begin
      // Latch the rectangle only when idle and inside the panel
      if (phase == lrfs_pkg::PH_IDLE && start_ok) begin
        col_start_next     = {1'b0, item.rect_x};
        col_end_next       = (w_clip != 10'd0) ? ({1'b0, item.rect_x} + w_clip - 10'd1)
                                               : {1'b0, item.rect_x};
        row_start_next     = {1'b0, item.rect_y};
        row_end_next       = (h_clip != 10'd0) ? ({1'b0, item.rect_y} + h_clip - 10'd1)
                                               : {1'b0, item.rect_y};
        held_color_next    = item.fill_color;
        pixels_left_next   = area[18:0];
        low_half_next_next = 1'b0;
        if (w_clip != 10'd0) begin
          phase_next = lrfs_pkg::PH_CASET;
        end else if (h_clip != 10'd0) begin
          phase_next = lrfs_pkg::PH_RASET;
        end else begin
          phase_next = lrfs_pkg::PH_RAMWR;
        end
      end
    end else if (fire) begin
      has_result = (phase != lrfs_pkg::PH_IDLE);
      case (phase)
        lrfs_pkg::PH_IDLE: ;
        lrfs_pkg::PH_CASET: begin
          result.out_byte = lrfs_pkg::CMD_COLUMN_SET;
          phase_next      = lrfs_pkg::PH_CBYTE0;
        end
        lrfs_pkg::PH_CBYTE0: begin
          result.out_byte = {5'b0, col_s_a[10:8]};
          result.is_data  = 1'b1;
          phase_next      = lrfs_pkg::PH_CBYTE1;
        end
        lrfs_pkg::PH_CBYTE1: begin
          result.out_byte = col_s_a[7:0];
          result.is_data  = 1'b1;
          phase_next      = lrfs_pkg::PH_CBYTE2;
        end
        lrfs_pkg::PH_CBYTE2: begin
          result.out_byte = {5'b0, col_e_a[10:8]};
          result.is_data  = 1'b1;
          phase_next      = lrfs_pkg::PH_CBYTE3;
        end
        lrfs_pkg::PH_CBYTE3: begin
          // Skip the row group when there is nothing to paint
          result.out_byte = col_e_a[7:0];
          result.is_data  = 1'b1;
          phase_next      = (pixels_left != 19'd0) ? lrfs_pkg::PH_RASET : lrfs_pkg::PH_RAMWR;
        end
        lrfs_pkg::PH_RASET: begin
          result.out_byte = lrfs_pkg::CMD_ROW_SET;
          phase_next      = lrfs_pkg::PH_RBYTE0;
        end
        lrfs_pkg::PH_RBYTE0: begin
          result.out_byte = {5'b0, row_s_a[10:8]};
          result.is_data  = 1'b1;
          phase_next      = lrfs_pkg::PH_RBYTE1;
        end
        lrfs_pkg::PH_RBYTE1: begin
          result.out_byte = row_s_a[7:0];
          result.is_data  = 1'b1;
          phase_next      = lrfs_pkg::PH_RBYTE2;
        end
        lrfs_pkg::PH_RBYTE2: begin
          result.out_byte = {5'b0, row_e_a[10:8]};
          result.is_data  = 1'b1;
          phase_next      = lrfs_pkg::PH_RBYTE3;
        end
        lrfs_pkg::PH_RBYTE3: begin
          result.out_byte = row_e_a[7:0];
          result.is_data  = 1'b1;
          phase_next      = lrfs_pkg::PH_RAMWR;
        end
        lrfs_pkg::PH_RAMWR: begin
          result.out_byte = lrfs_pkg::CMD_RAM_WRITE;
          if (pixels_left == 19'd0) begin
            result.last_byte = 1'b1;
            phase_next       = lrfs_pkg::PH_IDLE;
          end else begin
            phase_next         = lrfs_pkg::PH_PIXEL;
            low_half_next_next = 1'b0;
          end
        end
        lrfs_pkg::PH_PIXEL: begin
          // Send high byte then low byte, count the pixel on the low byte
          result.is_data = 1'b1;
          if (!low_half_next) begin
            result.out_byte    = held_color[15:8];
            low_half_next_next = 1'b1;
          end else begin
            result.out_byte    = held_color[7:0];
            low_half_next_next = 1'b0;
            pixels_left_next   = pixels_dec;
            if (pixels_dec == 19'd0) begin
              result.last_byte = 1'b1;
              phase_next       = lrfs_pkg::PH_IDLE;
            end
          end
        end
        default: begin
          // Unused codes return to idle without yielding a byte
          has_result = 1'b0;
          phase_next = lrfs_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= lrfs_pkg::PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_start     <= '0;
      col_end       <= '0;
      row_start     <= '0;
      row_end       <= '0;
      held_color    <= '0;
      pixels_left   <= '0;
      low_half_next <= 1'b0;
    end else begin
      col_start     <= col_start_next;
      col_end       <= col_end_next;
      row_start     <= row_start_next;
      row_end       <= row_end_next;
      held_color    <= held_color_next;
      pixels_left   <= pixels_left_next;
      low_half_next <= low_half_next_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lcd_rect_fill_sequencer.sv =====
// LCD rectangle fill sequencer: one command word in, at most one panel byte out.
// Each tick word passes the input register, then the output register, before its byte
// appears on lcd. Throughput: one word per cycle while the output is not stalled.
// Output stall back-pressures the input register, which then raises cmd_stall.
// Synchronous reset puts the sequencer in idle with panel 100 x 100, offsets zero.
// Depends on lrfs_pkg, lrfs_cfg_regs and lrfs_seq_core.
`default_nettype none

module lcd_rect_fill_sequencer (
  input  wire logic           clk,
  input  wire logic           rst,
  // Command words
  input  wire logic           cmd_valid,
  output logic                cmd_stall,
  input  wire lrfs_pkg::cmd_t cmd,
  // Panel bytes
  output logic                lcd_valid,
  input  wire logic           lcd_stall,
  output lrfs_pkg::lcd_t      lcd,
  // Register writes
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [15:0]    cfg_data
);

  logic           s1_valid;
  lrfs_pkg::cmd_t s1_item;
  logic           advance;
  logic           fire;
  logic           has_result;
  lrfs_pkg::lcd_t result;
  lrfs_pkg::cfg_t cfg;

  // Advance the input register whenever the output register can take a word
  assign advance   = !lcd_valid || !lcd_stall;
  assign cmd_stall = s1_valid && !advance;
  assign fire      = s1_valid && advance;
  assign cfg_ready = 1'b1;

  lrfs_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  lrfs_seq_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .item       (s1_item),
    .cfg        (cfg),
    .has_result (has_result),
    .result     (result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!cmd_stall) begin
      s1_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd_stall) begin
      s1_item <= cmd;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      lcd_valid <= 1'b0;
    end else if (advance) begin
      lcd_valid <= fire && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lcd <= result;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for lcd_rect_fill_sequencer: predicts the panel byte stream
// of each rectangle fill and checks every byte the block hands out.
// Depends on lrfs_pkg and the lcd_rect_fill_sequencer RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT   = 4000; // cycles with no word moving on any channel
  localparam int LATENCY_SLACK = 6;    // settle time after the last expected byte
  localparam int HOLD_OFF      = 300;  // long receiver hold-off, in cycles

  logic           clk;
  logic           rst;
  logic           cmd_valid;
  logic           cmd_stall;
  lrfs_pkg::cmd_t cmd_word;
  logic           lcd_valid;
  logic           lcd_stall;
  lrfs_pkg::lcd_t lcd_word;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [1:0]     cfg_index;
  logic [15:0]    cfg_data;

  // Predicted sequencer state and register copy
  lrfs_pkg::phase_t seq_state;
  logic [9:0]  col_first, col_last, row_first, row_last;
  logic [15:0] held_color;
  logic [18:0] pixels_left;
  logic        low_half_next;
  logic [9:0]  cfg_panel_w, cfg_panel_h;
  logic [7:0]  cfg_col_off, cfg_row_off;

  lrfs_pkg::lcd_t expected_bytes[$];

  int idle_pct, stall_pct, hold_left, quiet_cycles;
  int mismatches, bytes_checked, fills_latched, starts_dropped, words_ignored;
  int words_effective;

  lcd_rect_fill_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd_word),
    .lcd_valid (lcd_valid),
    .lcd_stall (lcd_stall),
    .lcd       (lcd_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Panel side as used for clipping
  function automatic int clip_side(logic [9:0] v);
    return (v > lrfs_pkg::MAX_SIDE) ? int'(lrfs_pkg::MAX_SIDE) : int'(v);
  endfunction

  // High or low byte of the start or end address, offset added
  function automatic logic [7:0] address_byte(logic [9:0] first, logic [9:0] last,
                                              logic [7:0] off, int k);
    logic [10:0] a;
    a = ((k < 2) ? first : last) + off;
    return (k % 2) ? a[7:0] : 8'(a >> 8);
  endfunction

  // Advance the predicted sequencer by one accepted word; queue any byte it yields
  function automatic void advance_sequence(lrfs_pkg::cmd_t w);
    int             pw, ph, x, y, wd, ht;
    lrfs_pkg::lcd_t b;
    pw = clip_side(cfg_panel_w);
    ph = clip_side(cfg_panel_h);
    if (w.operation == lrfs_pkg::OP_START) begin
      if (seq_state != lrfs_pkg::PH_IDLE) begin
        words_ignored++;
        return;
      end
      words_effective++;
      x  = w.rect_x;
      y  = w.rect_y;
      wd = w.rect_w;
      ht = w.rect_h;
      if (x >= pw || y >= ph) begin
        starts_dropped++;
        return;
      end
      if (x + wd > pw) wd = pw - x;
      if (y + ht > ph) ht = ph - y;
      col_first     = 10'(x);
      col_last      = (wd != 0) ? 10'(x + wd - 1) : 10'(x);
      row_first     = 10'(y);
      row_last      = (ht != 0) ? 10'(y + ht - 1) : 10'(y);
      held_color    = w.fill_color;
      pixels_left   = 19'(wd * ht);
      low_half_next = 1'b0;
      if (wd != 0)      seq_state = lrfs_pkg::PH_CASET;
      else if (ht != 0) seq_state = lrfs_pkg::PH_RASET;
      else              seq_state = lrfs_pkg::PH_RAMWR;
      fills_latched++;
      return;
    end
    if (seq_state == lrfs_pkg::PH_IDLE) begin
      words_ignored++;
      return;
    end
    words_effective++;
    b = '0;
    case (seq_state)
      lrfs_pkg::PH_CASET: begin
        b.out_byte = lrfs_pkg::CMD_COLUMN_SET;
        seq_state  = lrfs_pkg::PH_CBYTE0;
      end
      lrfs_pkg::PH_CBYTE0, lrfs_pkg::PH_CBYTE1,
      lrfs_pkg::PH_CBYTE2, lrfs_pkg::PH_CBYTE3: begin
        b.out_byte = address_byte(col_first, col_last, cfg_col_off,
                                  seq_state - lrfs_pkg::PH_CBYTE0);
        b.is_data  = 1'b1;
        if (seq_state == lrfs_pkg::PH_CBYTE3)
          seq_state = (pixels_left != 0) ? lrfs_pkg::PH_RASET : lrfs_pkg::PH_RAMWR;
        else
          seq_state = lrfs_pkg::phase_t'(seq_state + 1);
      end
      lrfs_pkg::PH_RASET: begin
        b.out_byte = lrfs_pkg::CMD_ROW_SET;
        seq_state  = lrfs_pkg::PH_RBYTE0;
      end
      lrfs_pkg::PH_RBYTE0, lrfs_pkg::PH_RBYTE1,
      lrfs_pkg::PH_RBYTE2, lrfs_pkg::PH_RBYTE3: begin
        b.out_byte = address_byte(row_first, row_last, cfg_row_off,
                                  seq_state - lrfs_pkg::PH_RBYTE0);
        b.is_data  = 1'b1;
        seq_state  = (seq_state == lrfs_pkg::PH_RBYTE3) ? lrfs_pkg::PH_RAMWR
                                                        : lrfs_pkg::phase_t'(seq_state + 1);
      end
      lrfs_pkg::PH_RAMWR: begin
        b.out_byte = lrfs_pkg::CMD_RAM_WRITE;
        if (pixels_left == 0) begin
          b.last_byte = 1'b1;
          seq_state   = lrfs_pkg::PH_IDLE;
        end else begin
          seq_state     = lrfs_pkg::PH_PIXEL;
          low_half_next = 1'b0;
        end
      end
      default: begin
        // Pixel bytes: high half, then low half, once per pixel
        b.is_data = 1'b1;
        if (!low_half_next) begin
          b.out_byte    = held_color[15:8];
          low_half_next = 1'b1;
        end else begin
          b.out_byte    = held_color[7:0];
          low_half_next = 1'b0;
          if (pixels_left != 0) pixels_left = pixels_left - 1'b1;
          if (pixels_left == 0) begin
            b.last_byte = 1'b1;
            seq_state   = lrfs_pkg::PH_IDLE;
          end
        end
      end
    endcase
    expected_bytes.push_back(b);
  endfunction

  function automatic lrfs_pkg::cmd_t start_word(int x, int y, int w, int h,
                                                logic [15:0] color);
    lrfs_pkg::cmd_t c;
    c.operation  = lrfs_pkg::OP_START;
    c.rect_x     = 9'(x);
    c.rect_y     = 9'(y);
    c.rect_w     = 10'(w);
    c.rect_h     = 10'(h);
    c.fill_color = color;
    return c;
  endfunction

  // Tick with random content in the fields it does not use
  function automatic lrfs_pkg::cmd_t tick_word();
    logic [63:0]    r;
    lrfs_pkg::cmd_t c;
    r = {$urandom, $urandom};
    c = r[$bits(lrfs_pkg::cmd_t)-1:0];
    c.operation = lrfs_pkg::OP_TICK;
    return c;
  endfunction

  // Offer one word, hold it until taken, then predict its effect
  task automatic send_word(lrfs_pkg::cmd_t w);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      cmd_valid = 1'b0;
    end
    @(negedge clk);
    cmd_valid = 1'b1;
    cmd_word  = w;
    do @(posedge clk); while (cmd_stall);
    advance_sequence(w);
  endtask

  // Drop valid and wait until every predicted byte has been seen
  task automatic drain_outputs();
    @(negedge clk);
    cmd_valid = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  // Drain, then let the pipeline settle before touching the registers
  task automatic quiesce();
    drain_outputs();
    repeat (LATENCY_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      lrfs_pkg::REG_PANEL_WIDTH:   cfg_panel_w = data[9:0];
      lrfs_pkg::REG_PANEL_HEIGHT:  cfg_panel_h = data[9:0];
      lrfs_pkg::REG_COLUMN_OFFSET: cfg_col_off = data[7:0];
      default:                     cfg_row_off = data[7:0];
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_panel(int pw, int ph, int coff, int roff);
    quiesce();
    write_reg(lrfs_pkg::REG_PANEL_WIDTH,   16'(pw));
    write_reg(lrfs_pkg::REG_PANEL_HEIGHT,  16'(ph));
    write_reg(lrfs_pkg::REG_COLUMN_OFFSET, 16'(coff));
    write_reg(lrfs_pkg::REG_ROW_OFFSET,    16'(roff));
  endtask

  task automatic finish_fill();
    while (seq_state != lrfs_pkg::PH_IDLE) send_word(tick_word());
  endtask

  // Start a fill and tick it to completion; optionally slip in starts while busy
  task automatic paint_rect(int x, int y, int w, int h, logic [15:0] color, bit noisy);
    send_word(start_word(x, y, w, h, color));
    while (seq_state != lrfs_pkg::PH_IDLE) begin
      if (noisy && $urandom_range(29) == 0)
        send_word(start_word($urandom_range(511), $urandom_range(511),
                             $urandom_range(512), $urandom_range(512), 16'($urandom)));
      else
        send_word(tick_word());
    end
  endtask

  // Receiver: random stall, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      lcd_stall = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      lcd_stall = ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each byte taken with the oldest prediction
  always @(posedge clk) begin : check_bytes
    lrfs_pkg::lcd_t want;
    if (!rst && lcd_valid && !lcd_stall) begin
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected panel byte %h (is_data %b, last_byte %b)",
               lcd_word.out_byte, lcd_word.is_data, lcd_word.last_byte);
        mismatches++;
      end else begin
        want = expected_bytes.pop_front();
        if (lcd_word.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, lcd_word.out_byte);
          mismatches++;
        end
        if (lcd_word.is_data !== want.is_data) begin
          $error("is_data: expected %b, got %b", want.is_data, lcd_word.is_data);
          mismatches++;
        end
        if (lcd_word.last_byte !== want.last_byte) begin
          $error("last_byte: expected %b, got %b", want.last_byte, lcd_word.last_byte);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (lcd_valid && !lcd_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // Reset panel: plain fills, empty groups, dropped and clipped starts, busy starts
  task automatic test_default_panel();
    idle_pct  = 0;
    stall_pct = 0;
    send_word(tick_word());
    paint_rect(2, 3, 3, 2, 16'hF81F, 1'b0);
    paint_rect(5, 5, 0, 2, 16'h1234, 1'b0);
    paint_rect(5, 5, 3, 0, 16'h4321, 1'b0);
    paint_rect(0, 0, 0, 0, 16'hFFFF, 1'b0);
    paint_rect(100, 0, 4, 4, 16'h0001, 1'b0);
    paint_rect(0, 100, 4, 4, 16'h0002, 1'b0);
    send_word(tick_word());
    paint_rect(97, 98, 512, 512, 16'hA55A, 1'b0);
    send_word(start_word(10, 20, 2, 1, 16'h00FF));
    send_word(tick_word());
    send_word(start_word(0, 0, 50, 50, 16'hFF00));
    finish_fill();
  endtask

  // Panel size and offset extremes, saturation above the maximum side, zero panel
  task automatic test_panel_extremes();
    set_panel(512, 512, 255, 255);
    // upper bits beyond the register are dropped
    write_reg(lrfs_pkg::REG_PANEL_WIDTH, 16'hFE00);
    write_reg(lrfs_pkg::REG_COLUMN_OFFSET, 16'hA5FF);
    paint_rect(511, 511, 512, 512, 16'h0000, 1'b0);
    paint_rect(0, 0, 1, 1, 16'hFFFF, 1'b0);
    set_panel(1023, 2, 0, 128);
    paint_rect(500, 1, 512, 512, 16'h5AA5, 1'b0);
    set_panel(1, 1, 0, 0);
    paint_rect(0, 0, 512, 512, 16'h8001, 1'b0);
    paint_rect(1, 0, 1, 1, 16'h7FFE, 1'b0);
    set_panel(0, 0, 0, 0);
    paint_rect(0, 0, 1, 1, 16'h1111, 1'b0);
    send_word(tick_word());
    set_panel(100, 100, 0, 0);
  endtask

  // Hold the receiver off while ticks keep coming, so the input side backs up
  task automatic test_output_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    quiesce();
    hold_left = HOLD_OFF;
    paint_rect(10, 10, 8, 4, 16'hC3C3, 1'b0);
    drain_outputs();
  endtask

  // Sender stops mid-fill until every byte so far has come out, then resumes
  task automatic test_sender_pause();
    int n;
    idle_pct  = 30;
    stall_pct = 30;
    send_word(start_word(20, 30, 5, 3, 16'h3C96));
    for (n = 0; n < 20; n++) send_word(tick_word());
    drain_outputs();
    finish_fill();
    drain_outputs();
  endtask

  task automatic random_panel();
    int pw, ph;
    pw = ($urandom_range(3) == 0) ? 512 : $urandom_range(1, 512);
    ph = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 512);
    if ($urandom_range(7) == 0) pw = $urandom_range(513, 1023);
    set_panel(pw, ph, $urandom_range(255), $urandom_range(255));
  endtask

  // Mostly well-formed fills with random content; the rest drops and stray ticks
  task automatic run_random(int target);
    int goal, pick, pw, ph, x, y, wd, ht;
    goal = words_effective + target;
    pw   = clip_side(cfg_panel_w);
    ph   = clip_side(cfg_panel_h);
    while (words_effective < goal) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        x  = $urandom_range(pw - 1);
        y  = $urandom_range(ph - 1);
        wd = $urandom_range(6);
        ht = $urandom_range(5);
        if ($urandom_range(9) == 0) begin
          x  = (pw > 4) ? pw - $urandom_range(1, 4) : 0;
          wd = $urandom_range(512);
        end
        if ($urandom_range(9) == 0) begin
          y  = (ph > 4) ? ph - $urandom_range(1, 4) : 0;
          ht = $urandom_range(512);
        end
        paint_rect(x, y, wd, ht, 16'($urandom), 1'b1);
      end else if (pick < 90 && (pw < 512 || ph < 512)) begin
        if (pw < 512 && (ph == 512 || $urandom_range(1)))
          send_word(start_word($urandom_range(pw, 511), $urandom_range(511),
                               $urandom_range(512), $urandom_range(512), 16'($urandom)));
        else
          send_word(start_word($urandom_range(511), $urandom_range(ph, 511),
                               $urandom_range(512), $urandom_range(512), 16'($urandom)));
      end else begin
        send_word(tick_word());
      end
    end
  endtask

  task automatic test_random_traffic();
    idle_pct = 0;  stall_pct = 0;  random_panel(); run_random(100);
    idle_pct = 87; stall_pct = 0;  random_panel(); run_random(90);
    idle_pct = 0;  stall_pct = 87; random_panel(); run_random(90);
    idle_pct = 30; stall_pct = 30; random_panel(); run_random(90);
    idle_pct = 0;  stall_pct = 0;
  endtask

  initial begin
    rst          = 1'b1;
    cmd_valid    = 1'b0;
    cmd_word     = '0;
    lcd_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = lrfs_pkg::REG_PANEL_WIDTH;
    cfg_data     = '0;
    seq_state    = lrfs_pkg::PH_IDLE;
    col_first    = '0;
    col_last     = '0;
    row_first    = '0;
    row_last     = '0;
    held_color   = '0;
    pixels_left  = '0;
    low_half_next = 1'b0;
    cfg_panel_w  = 10'd100;
    cfg_panel_h  = 10'd100;
    cfg_col_off  = '0;
    cfg_row_off  = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_left    = 0;
    quiet_cycles = 0;
    mismatches   = 0;
    bytes_checked = 0;
    fills_latched = 0;
    starts_dropped = 0;
    words_ignored = 0;
    words_effective = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_panel();
    test_panel_extremes();
    test_output_backpressure();
    test_sender_pause();
    test_random_traffic();

    quiesce();
    if (expected_bytes.size() != 0) begin
      $error("%0d predicted bytes never arrived", expected_bytes.size());
      mismatches++;
    end
    $display("Summary: %0d fills latched, %0d starts dropped, %0d words ignored,",
             fills_latched, starts_dropped, words_ignored);
    $display("         %0d panel bytes checked across idle, stall and hold-off phases",
             bytes_checked);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== lcd_rect_fill_sequencer.f =====
sv/lrfs_pkg.sv
sv/lrfs_cfg_regs.sv
sv/lrfs_seq_core.sv
sv/lcd_rect_fill_sequencer.sv
tb/sv/tb.sv
